// ===== src/ppp_pkg.sv =====
// Package for the pinhole point projection block.
// Holds register map codes, reset values and arithmetic width constants; no dependencies.
`default_nettype none
package ppp_pkg;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_XOFS   = 3'd2,
    REG_ZOFS   = 3'd3,
    REG_FOCAL  = 3'd4,
    REG_CU     = 3'd5,
    REG_CV     = 3'd6,
    REG_UNUSED = 3'd7
  } reg_idx_t;

  // Reset values
  localparam logic [17:0] COS_RST   = 18'd65536;
  localparam logic [17:0] SIN_RST   = 18'd0;
  localparam logic [31:0] XOFS_RST  = 32'd0;
  localparam logic [31:0] ZOFS_RST  = 32'd7208960;
  localparam logic [19:0] FOCAL_RST = 20'd100908;
  localparam logic [15:0] CU_RST    = 16'd20744;
  localparam logic [15:0] CV_RST    = 16'd15560;

  // Arithmetic widths
  localparam int ANGLE_FRAC = 16;
  localparam int PW = 51;  // rotation sum width
  localparam int YW = 35;  // rotated y
  localparam int ZW = 36;  // translated depth
  localparam int NW = 60;  // rounded dividend 2n+d
  localparam int DW = 37;  // divisor 2d
  localparam int QB = 34;  // quotient bits computed; more saturates anyway
  localparam int CW = NW + 11; // compare width, covers DW + QB

endpackage
`default_nettype wire

// ===== src/pinhole_point_projection.sv =====
// Pinhole point projection top level: rotation, translation, projection.
// Depends on ppp_pkg.
`default_nettype none
// Each item is a 3D point; one projected result item comes out per point.
// Fully pipelined: a point can enter every cycle. The radix-2 divider computes
// one quotient bit per stage for u and v in parallel. The whole pipeline stalls
// together when the output register holds an untaken item. Registers are to be
// written only while idle; the block itself does not enforce this.
module pinhole_point_projection
  import ppp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input points
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // point_x, point_y, point_z
  input  wire logic        in_tlast,   // last_in
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // image_u, image_v
  output logic [1:0]       out_tuser,  // zero_depth, clipped
  output logic             out_tlast,  // last_out
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // ---------------- configuration registers ----------------
  logic signed [17:0] cos_r, sin_r;
  logic signed [31:0] xofs_r, zofs_r;
  logic [19:0]        focal_r;
  logic [15:0]        cu_r, cv_r;
  reg_idx_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= COS_RST;
      sin_r   <= SIN_RST;
      xofs_r  <= XOFS_RST;
      zofs_r  <= ZOFS_RST;
      focal_r <= FOCAL_RST;
      cu_r    <= CU_RST;
      cv_r    <= CV_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_idx)
        REG_COS:   cos_r   <= cfg_pwdata[17:0];
        REG_SIN:   sin_r   <= cfg_pwdata[17:0];
        REG_XOFS:  xofs_r  <= cfg_pwdata;
        REG_ZOFS:  zofs_r  <= cfg_pwdata;
        REG_FOCAL: focal_r <= cfg_pwdata[19:0];
        REG_CU:    cu_r    <= cfg_pwdata[15:0];
        REG_CV:    cv_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_idx)
      REG_COS:   cfg_prdata = {14'd0, cos_r};
      REG_SIN:   cfg_prdata = {14'd0, sin_r};
      REG_XOFS:  cfg_prdata = xofs_r;
      REG_ZOFS:  cfg_prdata = zofs_r;
      REG_FOCAL: cfg_prdata = {12'd0, focal_r};
      REG_CU:    cfg_prdata = {16'd0, cu_r};
      REG_CV:    cfg_prdata = {16'd0, cv_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic ce;
  assign ce        = out_tready || !out_tvalid;
  assign in_tready = ce && rst_n;  // no item taken during reset

  // ---------------- stage 1: rotation products, x translation ----------------
  logic signed [31:0] px, py, pz;
  logic               s1_v_r, s1_last_r;
  logic signed [32:0] s1_cx_r;
  logic signed [49:0] s1_cy_r, s1_sz_r, s1_sy_r, s1_cz_r;

  assign px = in_tdata[31:0];
  assign py = in_tdata[63:32];
  assign pz = in_tdata[95:64];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (ce) s1_v_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      s1_last_r <= in_tlast;
      s1_cx_r   <= 33'(px) + 33'(xofs_r);
      s1_cy_r   <= 50'(cos_r * py);
      s1_sz_r   <= 50'(sin_r * pz);
      s1_sy_r   <= 50'(sin_r * py);
      s1_cz_r   <= 50'(cos_r * pz);
    end
  end

  // ---------------- stage 2: round rotated y, z; add depth offset ----------------
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (ANGLE_FRAC - 1);
  logic signed [PW-1:0] rot_y, rot_z;
  logic signed [YW-1:0] rz_sh;
  logic               s2_v_r, s2_last_r;
  logic signed [32:0] s2_cx_r;
  logic signed [YW-1:0] s2_cy_r;
  logic signed [ZW-1:0] s2_cz_r;

  assign rot_y = PW'(s1_cy_r) - PW'(s1_sz_r) + HALF;
  assign rot_z = PW'(s1_sy_r) + PW'(s1_cz_r) + HALF;
  assign rz_sh = rot_z[PW-1:ANGLE_FRAC];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (ce) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      s2_last_r <= s1_last_r;
      s2_cx_r   <= s1_cx_r;
      s2_cy_r   <= rot_y[PW-1:ANGLE_FRAC];
      s2_cz_r   <= ZW'(rz_sh) + ZW'(zofs_r);
    end
  end

  // ---------------- stage 3: focal products ----------------
  logic signed [24:0] f16;
  logic               s3_v_r, s3_last_r, s3_zero_r;
  logic signed [NW-1:0] s3_nu_r, s3_nv_r;
  logic signed [ZW-1:0] s3_cz_r;

  assign f16 = {1'b0, focal_r, 4'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (ce) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      s3_last_r <= s2_last_r;
      s3_zero_r <= (s2_cz_r == '0);
      s3_cz_r   <= s2_cz_r;
      s3_nu_r   <= NW'(f16 * s2_cx_r);
      s3_nv_r   <= NW'(f16 * s2_cy_r);
    end
  end

  // ---------------- stage 4: magnitudes, rounding bias, overflow ----------------
  logic [NW-1:0] mag_u, mag_v, nr_u, nr_v;
  logic [ZW-1:0] mag_z;
  logic [DW-1:0] den2;
  logic [CW-1:0] den_top;

  assign mag_u   = s3_nu_r[NW-1] ? NW'(-s3_nu_r) : NW'(s3_nu_r);
  assign mag_v   = s3_nv_r[NW-1] ? NW'(-s3_nv_r) : NW'(s3_nv_r);
  assign mag_z   = s3_cz_r[ZW-1] ? ZW'(-s3_cz_r) : ZW'(s3_cz_r);
  assign den2    = {mag_z, 1'b0};
  assign nr_u    = {mag_u[NW-2:0], 1'b0} + NW'(mag_z);
  assign nr_v    = {mag_v[NW-2:0], 1'b0} + NW'(mag_z);
  assign den_top = CW'(den2) << QB;

  // divider pipeline, index k holds the state after k quotient bits
  logic           dv_v_r    [0:QB];
  logic           dv_last_r [0:QB];
  logic           dv_zero_r [0:QB];
  logic           dv_negu_r [0:QB];
  logic           dv_negv_r [0:QB];
  logic           dv_ovfu_r [0:QB];
  logic           dv_ovfv_r [0:QB];
  logic [DW-1:0]  dv_den_r  [0:QB];
  logic [NW-1:0]  dv_ru_r   [0:QB];
  logic [NW-1:0]  dv_rv_r   [0:QB];
  logic [QB-1:0]  dv_qu_r   [0:QB];
  logic [QB-1:0]  dv_qv_r   [0:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (ce) dv_v_r[0] <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      dv_last_r[0] <= s3_last_r;
      dv_zero_r[0] <= s3_zero_r;
      dv_negu_r[0] <= s3_nu_r[NW-1] ^ s3_cz_r[ZW-1];
      dv_negv_r[0] <= s3_nv_r[NW-1] ^ s3_cz_r[ZW-1];
      dv_ovfu_r[0] <= (CW'(nr_u) >= den_top);
      dv_ovfv_r[0] <= (CW'(nr_v) >= den_top);
      dv_den_r[0]  <= den2;
      dv_ru_r[0]   <= nr_u;
      dv_rv_r[0]   <= nr_v;
      dv_qu_r[0]   <= '0;
      dv_qv_r[0]   <= '0;
    end
  end

  // ---------------- stages 5..: restoring divide, one bit per stage ----------------
  for (genvar k = 1; k <= QB; k++) begin : g_div
    localparam int SH = QB - k;
    logic [CW-1:0] dsh;
    logic          geu, gev;

    assign dsh = CW'(dv_den_r[k-1]) << SH;
    assign geu = CW'(dv_ru_r[k-1]) >= dsh;
    assign gev = CW'(dv_rv_r[k-1]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k] <= 1'b0;
      else if (ce) dv_v_r[k] <= dv_v_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        dv_last_r[k] <= dv_last_r[k-1];
        dv_zero_r[k] <= dv_zero_r[k-1];
        dv_negu_r[k] <= dv_negu_r[k-1];
        dv_negv_r[k] <= dv_negv_r[k-1];
        dv_ovfu_r[k] <= dv_ovfu_r[k-1];
        dv_ovfv_r[k] <= dv_ovfv_r[k-1];
        dv_den_r[k]  <= dv_den_r[k-1];
        dv_ru_r[k]   <= geu ? NW'(CW'(dv_ru_r[k-1]) - dsh) : dv_ru_r[k-1];
        dv_rv_r[k]   <= gev ? NW'(CW'(dv_rv_r[k-1]) - dsh) : dv_rv_r[k-1];
        dv_qu_r[k]   <= dv_qu_r[k-1] | (QB'(geu) << SH);
        dv_qv_r[k]   <= dv_qv_r[k-1] | (QB'(gev) << SH);
      end
    end
  end

  // ---------------- output stage: sign, center, saturate ----------------
  localparam int SW = QB + 2;
  logic signed [SW-1:0] su, sv;
  logic                 satu, satv;
  logic [31:0]          ou, ov;

  assign su = (dv_negu_r[QB] ? -SW'(dv_qu_r[QB]) : SW'(dv_qu_r[QB])) + SW'(cu_r);
  assign sv = (dv_negv_r[QB] ? -SW'(dv_qv_r[QB]) : SW'(dv_qv_r[QB])) + SW'(cv_r);
  assign satu = dv_ovfu_r[QB] || (su[SW-1:31] != '0 && su[SW-1:31] != '1);
  assign satv = dv_ovfv_r[QB] || (sv[SW-1:31] != '0 && sv[SW-1:31] != '1);

  always_comb begin
    if (!satu) ou = su[31:0];
    else if (dv_negu_r[QB]) ou = 32'h8000_0000;
    else ou = 32'h7FFF_FFFF;
    if (!satv) ov = sv[31:0];
    else if (dv_negv_r[QB]) ov = 32'h8000_0000;
    else ov = 32'h7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (ce) out_tvalid <= dv_v_r[QB];
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      out_tlast <= dv_last_r[QB];
      if (dv_zero_r[QB]) begin
        out_tdata <= '0;
        out_tuser <= 2'b01;
      end else begin
        out_tdata <= {ov, ou};
        out_tuser <= {satu || satv, 1'b0};
      end
    end
  end

  // ---------------- checks ----------------
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("zero depth result not cleared");

  a_clip_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      out_tdata[31:0] == 32'h7FFF_FFFF || out_tdata[31:0] == 32'h8000_0000 ||
      out_tdata[63:32] == 32'h7FFF_FFFF || out_tdata[63:32] == 32'h8000_0000)
    else $error("clipped flag without saturated coordinate");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(s1_v_r) && $stable(dv_v_r[0]) && $stable(dv_v_r[QB]))
    else $error("pipeline advanced during stall");

endmodule
`default_nettype wire

// ===== dv/ppp_checker.sv =====
// Checker for the pinhole point projection block: watches both streams,
// predicts each projected item from the register copy and compares. Uses ppp_pkg.
module ppp_checker
  import ppp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [95:0] in_tdata,   // point_x, point_y, point_z
  input  wire logic        in_tlast,   // last_in
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [63:0] out_tdata,  // image_u, image_v
  input  wire logic [1:0]  out_tuser,  // zero_depth, clipped
  input  wire logic        out_tlast,  // last_out
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [31:0] u;
    logic [31:0] v;
    logic        zero;
    logic        clip;
    logic        last;
  } proj_t;

  proj_t projections[$];

  logic signed [17:0] cos_r, sin_r;
  logic signed [31:0] xofs_r, zofs_r;
  logic [19:0]        focal_r;
  logic [15:0]        cu_r, cv_r;

  // round to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    logic neg;
    logic [63:0] n, d, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp32(longint s, inout logic clip);
    if (s > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (s < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return s;
  endfunction

  function automatic proj_t project(logic [95:0] d, logic lst);
    longint px, py, pz, rx, ry, rz, f16;
    proj_t r;
    px = longint'($signed(d[31:0]));
    py = longint'($signed(d[63:32]));
    pz = longint'($signed(d[95:64]));
    rx = px + longint'(xofs_r);
    // arithmetic shift is floor for the signed sum
    ry = (longint'(cos_r) * py - longint'(sin_r) * pz + 32768) >>> ANGLE_FRAC;
    rz = ((longint'(sin_r) * py + longint'(cos_r) * pz + 32768) >>> ANGLE_FRAC)
         + longint'(zofs_r);
    r = '0;
    r.last = lst;
    if (rz == 0) begin
      r.zero = 1'b1;
    end else begin
      f16 = longint'(focal_r) * 16;
      r.u = 32'(clamp32(round_div(f16 * rx, rz) + longint'(cu_r), r.clip));
      r.v = 32'(clamp32(round_div(f16 * ry, rz) + longint'(cv_r), r.clip));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    proj_t exp_r;
    int    errs;
    errs = 0;
    if (!rst_n) begin
      cos_r <= COS_RST; sin_r <= SIN_RST; xofs_r <= XOFS_RST; zofs_r <= ZOFS_RST;
      focal_r <= FOCAL_RST; cu_r <= CU_RST; cv_r <= CV_RST;
      fail_count <= 0;
      projections.delete();
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_COS:   cos_r <= cfg_pwdata[17:0];
          REG_SIN:   sin_r <= cfg_pwdata[17:0];
          REG_XOFS:  xofs_r <= cfg_pwdata;
          REG_ZOFS:  zofs_r <= cfg_pwdata;
          REG_FOCAL: focal_r <= cfg_pwdata[19:0];
          REG_CU:    cu_r <= cfg_pwdata[15:0];
          REG_CV:    cv_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (projections.size() == 0) begin
          $error("result item with no prediction waiting");
          errs = errs + 1;
        end else begin
          exp_r = projections.pop_front();
          if (out_tdata[31:0] !== exp_r.u) begin
            $error("image_u expected %0d got %0d", $signed(exp_r.u), $signed(out_tdata[31:0]));
            errs = errs + 1;
          end
          if (out_tdata[63:32] !== exp_r.v) begin
            $error("image_v expected %0d got %0d", $signed(exp_r.v), $signed(out_tdata[63:32]));
            errs = errs + 1;
          end
          if (out_tuser[0] !== exp_r.zero) begin
            $error("zero_depth expected %0b got %0b", exp_r.zero, out_tuser[0]);
            errs = errs + 1;
          end
          if (out_tuser[1] !== exp_r.clip) begin
            $error("clipped expected %0b got %0b", exp_r.clip, out_tuser[1]);
            errs = errs + 1;
          end
          if (out_tlast !== exp_r.last) begin
            $error("last_out expected %0b got %0b", exp_r.last, out_tlast);
            errs = errs + 1;
          end
        end
      end
      // new prediction after the result check of this edge
      if (in_tvalid && in_tready) projections = {projections, project(in_tdata, in_tlast)};
      if (errs != 0) fail_count <= fail_count + errs;
    end
    pending <= projections.size();
  end

endmodule

// ===== dv/pinhole_point_projection_tb.sv =====
// Testbench top for pinhole_point_projection: clock, reset, register setup,
// directed and random points, random stalls. Depends on ppp_pkg and ppp_checker.
module pinhole_point_projection_tb;
  import ppp_pkg::*;

  localparam int LATENCY   = 39;
  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending;
  int          idle_cycles = 0;
  logic        hold_off = 1'b0;
  logic        sending = 1'b0;

  always #1 clk = ~clk;

  pinhole_point_projection u_top (.*);

  ppp_checker u_chk (.*);

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !sending)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("pinhole_point_projection test failed");
      $finish;
    end
  end

  // receiver: random stall per item, long hold-off on request
  initial begin
    int w;
    forever begin
      if (!rst_n || hold_off) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (w > 0) begin
          out_tready <= 1'b0;
          repeat (w) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
        while (!out_tvalid) @(posedge clk);
      end
    end
  end

  // setup phase and access phase, then idle
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic lst, bit burst);
    int gap;
    gap = burst ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic random_config();
    int a;
    a = $urandom_range(0, 5);
    case (a)
      0: begin reg_write(REG_COS, 32'h10000); reg_write(REG_SIN, 32'h0); end
      1: begin reg_write(REG_COS, 32'h30000); reg_write(REG_SIN, 32'h10000); end
      2: begin reg_write(REG_COS, 32'h20000); reg_write(REG_SIN, 32'h1ffff); end
      default: begin reg_write(REG_COS, $urandom()); reg_write(REG_SIN, $urandom()); end
    endcase
    reg_write(REG_XOFS, $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 1 << 22)));
    reg_write(REG_ZOFS, $urandom_range(0, 3) == 0 ? $urandom()
                        : 32'($urandom_range(1 << 20, 300 << 16)));
    reg_write(REG_FOCAL, $urandom_range(0, 4) == 0 ? ($urandom_range(0, 1) ? 32'hfffff : 0)
                         : $urandom());
    reg_write(REG_CU, $urandom());
    reg_write(REG_CV, $urandom());
    reg_write(REG_UNUSED, $urandom());
  endtask

  initial begin
    int mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sending <= 1'b1;

    // directed: reset settings, extremes, zero depth, negative depth
    send_point(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b0);
    send_point(32'h00010000, 32'hffff0000, 32'hff920000, 1'b0, 1'b0);  // z cancels offset
    send_point(32'h00640000, 32'h00320000, 32'hff000000, 1'b1, 1'b0);  // negative depth
    send_point(32'h7fffffff, 32'h80000000, 32'hff930000, 1'b0, 1'b0);  // saturates
    send_point(32'hffffffff, 32'h00000001, 32'hff920001, 1'b1, 1'b0);
    drain();
    // extreme registers, out-of-range angle patterns
    reg_write(REG_COS, 32'h1ffff); reg_write(REG_SIN, 32'h20000);
    reg_write(REG_XOFS, 32'h80000000); reg_write(REG_ZOFS, 32'h7fffffff);
    reg_write(REG_FOCAL, 32'hfffff); reg_write(REG_CU, 32'hffff); reg_write(REG_CV, 32'h0);
    reg_write(REG_UNUSED, 32'hdeadbeef);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0);
    send_point(32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b0);
    send_point(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    drain();
    reg_write(REG_COS, 32'h0); reg_write(REG_SIN, 32'h0); reg_write(REG_ZOFS, 32'h0);
    reg_write(REG_FOCAL, 32'h0); reg_write(REG_CV, 32'hffff);
    send_point(32'h12345678, 32'h7fffffff, 32'h80000000, 1'b1, 1'b0);  // zero depth
    drain();

    // long receiver hold-off while the sender keeps pushing
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 120; i++)
        send_point(rand_coord(1), rand_coord(1), rand_coord(1),
                   1'($urandom_range(0, 1)), 1'b1);
    join
    drain();

    // random phases with fresh settings
    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      for (int i = 0; i < 200; i++) begin
        mode = $urandom_range(0, 9);
        mode = (mode < 6) ? 1 : (mode < 8) ? 0 : (mode == 8) ? 3 : 2;
        send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                   1'($urandom_range(0, 1)), ($urandom_range(0, 5) == 0));
      end
      drain();
    end

    if (fail_count == 0)
      $display("pinhole_point_projection test passed");
    else
      $display("pinhole_point_projection test failed");
    $finish;
  end

endmodule
